// ===== hw/rtl/fsks_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed slot key set package
// Shared types and constants for the key set scan chain and its controller.
// ----------------------------------------------------------------------------
package fsks_pkg;

    // Default number of key slots; the design supports 1 to 64.
    localparam int SLOTS_DEF = 8;

    // Slot index width covers the largest supported set of 64 slots.
    localparam int IDX_W = 6;
    // Occupancy width, as carried by the occupied result field.
    localparam int CNT_W = 7;
    localparam int KEY_W = 16;
    localparam int POS_W = 8;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_CONTAINS = 3'd2,
        MODE_COUNT    = 3'd3,
        MODE_AT       = 3'd4,
        MODE_CLEAR    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    // Scan token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic             active;
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] seen;
        logic             at_hit;
        logic [KEY_W-1:0] at_key;
    } token_t;

    // Slot update broadcast to all cells when a scan finishes.
    typedef struct packed {
        logic             clear_all;
        logic             set_en;
        logic             clr_en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } cmd_t;

endpackage

// ===== hw/rtl/fsks_cell.sv =====
// ----------------------------------------------------------------------------
// Key set slot cell
// Holds one slot (key and valid bit) and updates the passing scan token.
// ----------------------------------------------------------------------------
module fsks_cell
    import fsks_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    input  cmd_t   cmd,
    output token_t tok_out
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic             sel;
    logic             match;

    assign sel   = (cmd.idx == IDX_W'(IDX));
    assign match = valid_reg && (key_reg == tok_in.key);

    always_comb
    begin
        tok_next = tok_in;
        if (match && !tok_in.found)
        begin
            tok_next.found     = 1'b1;
            tok_next.found_idx = IDX_W'(IDX);
        end
        if (!valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = IDX_W'(IDX);
        end
        if (valid_reg && !tok_in.at_hit)
        begin
            // The position-th occupied slot, counted from zero.
            if ({1'b0, tok_in.seen} == tok_in.pos)
            begin
                tok_next.at_hit = 1'b1;
                tok_next.at_key = key_reg;
            end
            tok_next.seen = tok_in.seen + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (cmd.clear_all)
            begin
                valid_reg <= 1'b0;
            end
            else if (cmd.set_en && sel)
            begin
                valid_reg <= 1'b1;
            end
            else if (cmd.clr_en && sel)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_en && sel)
        begin
            key_reg <= cmd.key;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hw/rtl/fsks_ctrl.sv =====
// ----------------------------------------------------------------------------
// Key set controller
// Launches scan tokens, applies slot updates and holds the result register.
// ----------------------------------------------------------------------------
module fsks_ctrl
    import fsks_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output token_t      tok_launch,
    input  token_t      tok_end,
    output cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    status_t          stat_reg;
    status_t          stat_next;
    logic             hit_reg;
    logic             hit_next;
    logic [KEY_W-1:0] kout_reg;
    logic [KEY_W-1:0] kout_next;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;
    logic             accept;
    logic             emit_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The result moves into the output register once that register is free.
    assign emit_go  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        tok_launch        = '0;
        tok_launch.active = accept;
        tok_launch.mode   = mode_t'(s_tuser);
        tok_launch.key    = s_tdata[15:0];
        tok_launch.pos    = s_tdata[23:16];
    end

    // Decide the outcome once the token has passed every slot.
    always_comb
    begin
        cmd       = '0;
        cmd.key   = tok_end.key;
        occ_next  = occ_reg;
        stat_next = STAT_DONE;
        hit_next  = 1'b0;
        kout_next = '0;
        case (tok_end.mode)
            MODE_ADD:
            begin
                if (tok_end.found)
                begin
                    stat_next = STAT_PRESENT;
                end
                else if (tok_end.free_found)
                begin
                    cmd.set_en = tok_end.active;
                    cmd.idx    = tok_end.free_idx;
                    occ_next   = occ_reg + CNT_W'(1);
                end
                else
                begin
                    stat_next = STAT_FULL;
                end
            end
            MODE_REMOVE:
            begin
                if (tok_end.found)
                begin
                    cmd.clr_en = tok_end.active;
                    cmd.idx    = tok_end.found_idx;
                    occ_next   = occ_reg - CNT_W'(1);
                    hit_next   = 1'b1;
                end
                else
                begin
                    stat_next = STAT_MISSING;
                end
            end
            MODE_CONTAINS:
            begin
                if (tok_end.found)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    stat_next = STAT_MISSING;
                end
            end
            MODE_AT:
            begin
                if (tok_end.at_hit)
                begin
                    hit_next  = 1'b1;
                    kout_next = tok_end.at_key;
                end
                else
                begin
                    stat_next = STAT_MISSING;
                end
            end
            MODE_CLEAR:
            begin
                cmd.clear_all = tok_end.active;
                occ_next      = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            stat_reg     <= STAT_DONE;
            hit_reg      <= 1'b0;
            kout_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (emit_go)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {6'b0, kout_reg, occ_reg, hit_reg, stat_reg};
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (tok_end.active)
                    begin
                        occ_reg   <= occ_next;
                        stat_reg  <= stat_next;
                        hit_reg   <= hit_next;
                        kout_reg  <= kout_next;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(SLOTS))
        else $error("occupancy exceeds slot count");

    a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.active |-> state_reg == ST_SCAN)
        else $error("scan token finished outside a scan");

    a_set_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_en |-> occ_reg < CNT_W'(SLOTS))
        else $error("slot written while the set is full");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SCAN)
        else $error("accepted request did not start a scan");
`endif

endmodule

// ===== hw/rtl/fixed_slot_key_set_unit.sv =====
// A request's token passes through the SLOTS slot cells in order; the controller
// then registers the outcome and moves it into the output register. No new
// request is accepted until the result has moved into the output register.
// A finished result may wait in the output register while the next request
// is accepted and scanned.
// Reset (rst_n, asynchronous, active low) empties every slot at once.
// ----------------------------------------------------------------------------
// Fixed slot key set unit
// A set of up to SLOTS 16-bit keys kept in a chain of slot cells. Each request
// carries one operation (add, remove, contains, count, at, clear); a scan
// token walks the chain, gathering the lookup, the lowest free slot and the
// position-th occupied key, and the controller then commits the update and
// returns exactly one result.
// ----------------------------------------------------------------------------
module fixed_slot_key_set_unit
    import fsks_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key[15:0], position[23:16]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], hit[2], occupied[9:3],
                                   // key_out[25:10], zero fill above
);

    // Token stage i feeds cell i; stage SLOTS is the token leaving the chain.
    token_t tok [SLOTS+1];
    cmd_t   cmd;

    fsks_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .tok_launch(tok[0]),
        .tok_end   (tok[SLOTS]),
        .cmd       (cmd)
    );

    // The slot cells: each registers the token before handing it on, so a
    // scan visits the slots in turn. Slot updates are broadcast by index.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fsks_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tok_in (tok[i]),
            .cmd    (cmd),
            .tok_out(tok[i+1])
        );
    end

endmodule
